FILE: rtl/qlta_pkg.sv
`default_nettype none
package qlta_pkg;

  localparam int NUM_ACTIONS    = 4;
  localparam int ACT_W          = 2;
  localparam int Q_W            = 32;
  localparam int IDX_W          = 13;   // row*cols+col tops out at 63*127+63
  localparam int DEF_NUM_STATES = 1024;
  localparam int CFG_W          = 17;

  localparam logic [15:0] LR_RESET      = 16'd39322;
  localparam logic [16:0] DISC_RESET    = 17'd65536;
  localparam logic [15:0] HORIZON_RESET = 16'd10000;
  localparam logic [6:0]  COLS_RESET    = 7'd32;

  typedef enum logic [1:0] {
    CFG_LEARN_RATE = 2'd0,
    CFG_DISCOUNT   = 2'd1,
    CFG_HORIZON    = 2'd2,
    CFG_GRID_COLS  = 2'd3
  } cfg_idx_t;

  localparam logic CMD_CHOOSE = 1'b0;
  localparam logic CMD_LEARN  = 1'b1;

  typedef logic [NUM_ACTIONS-1:0][Q_W-1:0] q_row_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/qlta_if.sv
`default_nettype none
interface qlta_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  row;
  logic [5:0]  col;
  logic [1:0]  action;
  logic signed [15:0] reward;
  logic [5:0]  next_row;
  logic [5:0]  next_col;
  logic        done_req;
  logic [15:0] random_draw;
  logic [1:0]  random_action;
  logic        new_episode;

  modport source (
    output valid, command, row, col, action, reward, next_row, next_col,
           done_req, random_draw, random_action, new_episode,
    input  ready
  );
  modport sink (
    input  valid, command, row, col, action, reward, next_row, next_col,
           done_req, random_draw, random_action, new_episode,
    output ready
  );
endinterface

interface qlta_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  chosen_action;
  logic        explored;
  logic signed [31:0] new_value;
  logic        index_error;

  modport source (
    output valid, chosen_action, explored, new_value, index_error,
    input  ready
  );
  modport sink (
    input  valid, chosen_action, explored, new_value, index_error,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/qlta_ram.sv
`default_nettype none
module qlta_ram
  import qlta_pkg::*;
#(
  parameter int DEPTH = DEF_NUM_STATES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic     clk,
  input  ram_ctl_t ctl,
  input  logic [AW-1:0] waddr,
  input  q_row_t   wdata,
  input  logic [AW-1:0] raddr,
  output q_row_t   rdata_r
);

  // one row holds all actions of a cell
  q_row_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/qlta_row_max.sv
`default_nettype none
module qlta_row_max
  import qlta_pkg::*;
(
  input  q_row_t                 row,
  output logic signed [Q_W-1:0]  max_val,
  output logic [ACT_W-1:0]       best
);

  // strict compare keeps the first maximum
  always_comb begin
    max_val = $signed(row[0]);
    best    = '0;
    for (int j = 1; j < NUM_ACTIONS; j++) begin
      if ($signed(row[j]) > max_val) begin
        max_val = $signed(row[j]);
        best    = ACT_W'(j);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/qlearning_table_agent_unit.sv
`default_nettype none
// Tabular Q-learning agent. Each input word is a choose command (epsilon-greedy pick
// for a cell) or a learn command (saturating Q16.16 update of one entry from the
// reward and the best value of the next cell); every word yields exactly one result
// word. The Q table sits in one RAM with one row per cell, read through a registered
// port. A choose takes the index multiply and one row read; a learn takes the index
// multiply, two row reads through the single read port, then the discount multiply,
// the difference, the learning-rate multiply and the write-back.
// A word whose cell index is out of range skips the reads and goes straight to the result.
// After reset a clearing pass zeroes the table, one row per cycle, during which no
// input word is accepted; configuration writes are taken at any time. A finished
// result waits in an output register while the next word is already accepted.
module qlearning_table_agent_unit
  import qlta_pkg::*;
#(
  parameter int NUM_STATES = DEF_NUM_STATES
) (
  input  logic             clk,
  input  logic             rst_n,
  qlta_in_if.sink          in_ch,
  qlta_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(NUM_STATES);
  localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
  localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_IDX, S_RD_A, S_RD_B, S_MUL_D, S_DIFF, S_MUL_L, S_WB, S_OUT
  } state_t;

  typedef struct packed {
    logic        command;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [1:0]  action;
    logic [15:0] reward;
    logic [5:0]  next_row;
    logic [5:0]  next_col;
    logic        done_req;
    logic [15:0] random_draw;
    logic [1:0]  random_action;
    logic        new_episode;
  } item_t;

  state_t state_r;
  item_t  item_r;

  logic [15:0] lr_r;
  logic [16:0] discount_r;
  logic [15:0] horizon_r;
  logic [6:0]  cols_r;

  logic [AW-1:0]    clr_addr_r;
  logic [15:0]      step_r;
  logic             sticky_r;
  logic [IDX_W-1:0] s_r, ns_r, s_nxt, ns_nxt;
  logic [31:0]      hd_r, hd_nxt;
  logic             explore_r, explore_nxt;
  logic signed [Q_W-1:0] maxq_r;
  q_row_t           row_s_r;
  logic signed [33:0] disc_q_r, disc_nxt;
  logic signed [34:0] diff_r, diff_nxt;
  logic signed [35:0] delta_r, delta_nxt;

  logic [ACT_W-1:0]      res_act_r;
  logic                  res_exp_r;
  logic signed [Q_W-1:0] res_val_r;
  logic                  res_err_r;

  logic                  out_valid_r;
  logic [ACT_W-1:0]      out_act_r;
  logic                  out_exp_r;
  logic signed [Q_W-1:0] out_val_r;
  logic                  out_err_r;

  logic        is_learn, idx_err, out_free;
  logic [15:0] step_eff;
  logic [35:0] lhs, rhs;
  logic signed [49:0] prod_d;
  logic signed [51:0] prod_l;
  logic signed [Q_W-1:0] q_old, nv_sat, rm_max;
  logic signed [36:0] nv_wide;
  logic [ACT_W-1:0] rm_best;
  q_row_t   rdata, wr_row, wdata;
  ram_ctl_t ram_ctl;
  logic [AW-1:0] raddr, waddr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r       <= LR_RESET;
      discount_r <= DISC_RESET;
      horizon_r  <= HORIZON_RESET;
      cols_r     <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LEARN_RATE: lr_r       <= cfg_wdata[15:0];
        CFG_DISCOUNT:   discount_r <= cfg_wdata[16:0];
        CFG_HORIZON:    horizon_r  <= cfg_wdata[15:0];
        CFG_GRID_COLS:  cols_r     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign is_learn = (item_r.command == CMD_LEARN);
  assign out_free = !out_valid_r || out_ch.ready;

  assign s_nxt  = IDX_W'(item_r.row) * IDX_W'(cols_r) + IDX_W'(item_r.col);
  assign ns_nxt = IDX_W'(item_r.next_row) * IDX_W'(cols_r) + IDX_W'(item_r.next_col);
  assign hd_nxt = {16'b0, horizon_r} * {16'b0, item_r.random_draw};

  assign idx_err = (s_r >= IDX_W'(NUM_STATES)) ||
                   (is_learn && (ns_r >= IDX_W'(NUM_STATES)));

  // explore if the sticky flag is set or 10*horizon*draw < 65536*(horizon + 9*steps)
  assign step_eff    = item_r.new_episode ? '0 : step_r;
  assign lhs         = ({4'b0, hd_r} << 3) + ({4'b0, hd_r} << 1);
  assign rhs         = {({4'b0, horizon_r} + (20'(step_eff) << 3) + 20'(step_eff)), 16'b0};
  assign explore_nxt = sticky_r || (lhs < rhs);

  qlta_row_max u_row_max (
    .row     (rdata),
    .max_val (rm_max),
    .best    (rm_best)
  );

  // upper product bits are floor(x / 65536)
  assign prod_d   = $signed({1'b0, discount_r}) * maxq_r;
  assign disc_nxt = prod_d[49:16];

  assign q_old    = $signed(row_s_r[item_r.action]);
  assign diff_nxt = $signed({{3{item_r.reward[15]}}, item_r.reward, 16'b0})
                  + $signed({disc_q_r[33], disc_q_r})
                  - $signed({{3{q_old[31]}}, q_old});

  assign prod_l    = $signed({1'b0, lr_r}) * diff_r;
  assign delta_nxt = prod_l[51:16];

  assign nv_wide = $signed({{5{q_old[31]}}, q_old}) + $signed({delta_r[35], delta_r});

  always_comb begin
    if (nv_wide > SAT_HI) begin
      nv_sat = SAT_HI[31:0];
    end else if (nv_wide < SAT_LO) begin
      nv_sat = SAT_LO[31:0];
    end else begin
      nv_sat = nv_wide[31:0];
    end
  end

  always_comb begin
    wr_row = row_s_r;
    wr_row[item_r.action] = nv_sat;
  end

  // RAM access: learn reads the next cell first, then the current cell
  assign ram_ctl.we = (state_r == S_CLR) || (state_r == S_WB);
  assign ram_ctl.re = ((state_r == S_RD_A) && !idx_err) || ((state_r == S_RD_B) && is_learn);
  assign raddr      = ((state_r == S_RD_A) && is_learn) ? ns_r[AW-1:0] : s_r[AW-1:0];
  assign waddr      = (state_r == S_CLR) ? clr_addr_r : s_r[AW-1:0];
  assign wdata      = (state_r == S_CLR) ? '0 : wr_row;

  qlta_ram #(
    .DEPTH (NUM_STATES)
  ) u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      sticky_r    <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(NUM_STATES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r <= S_IDX;
          end
        end
        S_IDX:  state_r <= S_RD_A;
        S_RD_A: state_r <= idx_err ? S_OUT : S_RD_B;
        S_RD_B: begin
          if (item_r.command == CMD_CHOOSE) begin
            if (item_r.new_episode) begin
              step_r <= '0;
            end
            state_r <= S_OUT;
          end else begin
            state_r <= S_MUL_D;
          end
        end
        S_MUL_D: state_r <= S_DIFF;
        S_DIFF:  state_r <= S_MUL_L;
        S_MUL_L: state_r <= S_WB;
        S_WB: begin
          if (step_r != '1) begin
            step_r <= step_r + 1'b1;
          end
          if (item_r.done_req) begin
            sticky_r <= 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_r.command       <= in_ch.command;
          item_r.row           <= in_ch.row;
          item_r.col           <= in_ch.col;
          item_r.action        <= in_ch.action;
          item_r.reward        <= in_ch.reward;
          item_r.next_row      <= in_ch.next_row;
          item_r.next_col      <= in_ch.next_col;
          item_r.done_req      <= in_ch.done_req;
          item_r.random_draw   <= in_ch.random_draw;
          item_r.random_action <= in_ch.random_action;
          item_r.new_episode   <= in_ch.new_episode;
        end
      end
      S_IDX: begin
        s_r  <= s_nxt;
        ns_r <= ns_nxt;
        hd_r <= hd_nxt;
      end
      S_RD_A: begin
        explore_r <= explore_nxt;
        res_err_r <= idx_err;
        res_act_r <= '0;
        res_exp_r <= 1'b0;
        res_val_r <= '0;
      end
      S_RD_B: begin
        if (item_r.command == CMD_CHOOSE) begin
          res_act_r <= explore_r ? item_r.random_action : rm_best;
          res_exp_r <= explore_r;
          res_val_r <= rm_max;
        end else begin
          maxq_r <= rm_max;
        end
      end
      S_MUL_D: begin
        row_s_r  <= rdata;
        disc_q_r <= disc_nxt;
      end
      S_DIFF:  diff_r  <= diff_nxt;
      S_MUL_L: delta_r <= delta_nxt;
      S_WB:    res_val_r <= nv_sat;
      S_OUT: begin
        if (out_free) begin
          out_act_r <= res_act_r;
          out_exp_r <= res_exp_r;
          out_val_r <= res_val_r;
          out_err_r <= res_err_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.chosen_action = out_act_r;
  assign out_ch.explored      = out_exp_r;
  assign out_ch.new_value     = out_val_r;
  assign out_ch.index_error   = out_err_r;

`ifndef SYNTHESIS
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != $past(step_r)) |-> (step_r == '0 || step_r == $past(step_r) + 16'd1))
    else $error("step count moved other than clear or increment");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(sticky_r) |-> sticky_r)
    else $error("always-explore flag dropped");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.index_error) |->
      (out_ch.new_value == '0 && !out_ch.explored && out_ch.chosen_action == '0))
    else $error("index error word carries nonzero fields");

  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ram_ctl.we |-> !ram_ctl.re)
    else $error("table read and write in the same cycle");
`endif

endmodule
`default_nettype wire
